// ----- design/mbfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the mailbox byte FIFO packetiser.
// No dependencies.

package mbfp_pkg;

    localparam int OP_W    = 2;
    localparam int CH_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 2;
    localparam int MASK_W  = 4;

    // most bytes carried by one mailbox word
    localparam int PKT_MAX = 3;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam op_t OP_HOST_WR = 2'd0;
    localparam op_t OP_HOST_RD = 2'd1;
    localparam op_t OP_TX_EMPTY = 2'd2;
    localparam op_t OP_RX_WORD = 2'd3;

    localparam count_t PKT_MAX_CNT = count_t'(PKT_MAX);

endpackage

// ----- design/mbfp_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port synchronous RAM, registered read.
// No dependencies.

module mbfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mailbox_byte_fifo_packetizer_top.sv -----
`timescale 1ns / 1ps
// Mailbox byte FIFO packetiser: per-channel tx/rx byte rings in one RAM (mbfp_ram, mbfp_pkg).
// One request at a time. The engine moves bytes in push or pop until the run reaches its limit
// or stops short of it (ring empty or full, zero count), then loads the result from done and
// returns to idle; a held result stalls it in done. aresetn (sync, active low) clears pointers,
// irq enables, control.

module mailbox_byte_fifo_packetizer_top #(
    parameter int RING_DEPTH = 256,
    parameter int CHANNELS   = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mbfp_pkg::OP_W-1:0]    s_operation,
    input  logic [mbfp_pkg::CH_W-1:0]    s_channel,
    input  logic [mbfp_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic [mbfp_pkg::WORD_W-1:0]  s_rx_word,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_accepted,
    output logic [mbfp_pkg::BYTE_W-1:0]  m_read_byte,
    output logic                         m_tx_word_valid,
    output logic [mbfp_pkg::WORD_W-1:0]  m_tx_word,
    output logic [mbfp_pkg::COUNT_W-1:0] m_byte_count,
    output logic [mbfp_pkg::MASK_W-1:0]  m_tx_irq_mask
);

    import mbfp_pkg::*;

    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int NRINGS    = 2 * CHANNELS;
    localparam int RING_W    = $clog2(NRINGS);
    localparam int AW        = RING_W + PTR_W;
    localparam int MEM_DEPTH = NRINGS * (2 ** PTR_W);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg;
    op_t               op_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              ch_ok_reg;
    logic [RING_W-1:0] ring_reg;
    count_t            lim_reg;
    count_t            cnt_reg;
    byte_t             bytes_reg [PKT_MAX];
    logic              pend_reg;
    count_t            slot_reg;
    logic [MASK_W-1:0] irq_en_reg;
    logic [PTR_W-1:0]  rp_reg [NRINGS];
    logic [PTR_W-1:0]  wp_reg [NRINGS];

    logic              m_valid_reg;
    logic              m_accepted_reg;
    byte_t             m_read_byte_reg;
    logic              m_tx_word_valid_reg;
    logic [WORD_W-1:0] m_tx_word_reg;
    count_t            m_byte_count_reg;

    // accept-side decode
    logic              ch_ok;
    logic              rx_side;
    logic [2:0]        ring_wide;
    count_t            lim_next;
    byte_t             bytes_next [PKT_MAX];

    // ring engine
    logic [PTR_W-1:0]  rp_cur, wp_cur, rp_adv, wp_adv;
    logic              ring_empty, ring_full;
    logic              push_go, pop_go, last_step;
    count_t            wr_idx;
    byte_t             bytes_cur [PKT_MAX];
    logic              ram_en;
    logic [AW-1:0]     ram_addr;
    byte_t             ram_rdata;

    // completion
    logic              out_free, done_fire;
    logic [MASK_W-1:0] irq_en_next;
    logic              cnt_nz;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        ch_ok     = (32'(s_channel) < CHANNELS);
        rx_side   = (s_operation == OP_HOST_RD) || (s_operation == OP_RX_WORD);
        ring_wide = {s_channel, rx_side};
        case (s_operation)
            OP_HOST_WR, OP_HOST_RD: lim_next = count_t'(1);
            OP_TX_EMPTY:            lim_next = PKT_MAX_CNT;
            OP_RX_WORD:             lim_next = (s_rx_word[7:0] > 8'(PKT_MAX)) ? PKT_MAX_CNT
                                                                              : s_rx_word[1:0];
            default:                lim_next = '0;
        endcase
        for (int i = 0; i < PKT_MAX; i++) begin
            bytes_next[i] = (s_operation == OP_RX_WORD) ? s_rx_word[8 + 8*i +: 8] : '0;
        end
        if (s_operation == OP_HOST_WR) begin
            bytes_next[0] = s_data_byte;
        end
    end

    always_comb begin
        rp_cur     = rp_reg[ring_reg];
        wp_cur     = wp_reg[ring_reg];
        rp_adv     = (rp_cur == PTR_LAST) ? '0 : rp_cur + 1'b1;
        wp_adv     = (wp_cur == PTR_LAST) ? '0 : wp_cur + 1'b1;
        ring_empty = (rp_cur == wp_cur);
        ring_full  = (wp_adv == rp_cur);
        push_go    = (state_reg == ST_PUSH) && (cnt_reg < lim_reg) && !ring_full;
        pop_go     = (state_reg == ST_POP) && (cnt_reg < lim_reg) && !ring_empty;
        last_step  = ((cnt_reg + 1'b1) == lim_reg);
        wr_idx     = (cnt_reg == PKT_MAX_CNT) ? '0 : cnt_reg;
        ram_en     = push_go || pop_go;
        ram_addr   = {ring_reg, (push_go ? wp_cur : rp_cur)};
        // merge the byte still in the RAM output register
        for (int i = 0; i < PKT_MAX; i++) begin
            bytes_cur[i] = (pend_reg && (slot_reg == count_t'(i))) ? ram_rdata : bytes_reg[i];
        end
    end

    mbfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_ring_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (push_go),
        .addr  (ram_addr),
        .wdata (bytes_reg[wr_idx]),
        .rdata (ram_rdata)
    );

    always_comb begin
        out_free    = !m_valid_reg || m_ready;
        done_fire   = (state_reg == ST_DONE) && out_free;
        cnt_nz      = (cnt_reg != '0);
        irq_en_next = irq_en_reg;
        if (ch_ok_reg && (op_reg == OP_HOST_WR) && cnt_nz) begin
            irq_en_next[ch_reg] = 1'b1;
        end
        if (ch_ok_reg && (op_reg == OP_TX_EMPTY) && !cnt_nz) begin
            irq_en_next[ch_reg] = 1'b0;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            irq_en_reg  <= '0;
            m_valid_reg <= 1'b0;
            for (int r = 0; r < NRINGS; r++) begin
                rp_reg[r] <= '0;
                wp_reg[r] <= '0;
            end
        end else begin
            if (done_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (!ch_ok) begin
                            state_reg <= ST_DONE;
                        end else if ((s_operation == OP_HOST_WR) ||
                                     (s_operation == OP_RX_WORD)) begin
                            // host write and received word push; the others pop
                            state_reg <= ST_PUSH;
                        end else begin
                            state_reg <= ST_POP;
                        end
                    end
                end
                ST_PUSH: begin
                    if (push_go) begin
                        wp_reg[ring_reg] <= wp_adv;
                    end
                    if (!push_go || last_step) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_POP: begin
                    pend_reg <= pop_go;
                    if (pop_go) begin
                        rp_reg[ring_reg] <= rp_adv;
                    end
                    if (!pop_go || last_step) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        pend_reg    <= 1'b0;
                        irq_en_reg  <= irq_en_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_valid) begin
            op_reg    <= s_operation;
            ch_reg    <= s_channel;
            ch_ok_reg <= ch_ok;
            ring_reg  <= ring_wide[RING_W-1:0];
            lim_reg   <= lim_next;
            cnt_reg   <= '0;
            for (int i = 0; i < PKT_MAX; i++) begin
                bytes_reg[i] <= bytes_next[i];
            end
        end
        if (push_go || pop_go) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (pop_go) begin
            slot_reg <= cnt_reg;
        end
        if (state_reg == ST_POP) begin
            for (int i = 0; i < PKT_MAX; i++) begin
                bytes_reg[i] <= bytes_cur[i];
            end
        end
        if (done_fire) begin
            m_accepted_reg      <= ((op_reg == OP_HOST_WR) || (op_reg == OP_HOST_RD)) && cnt_nz;
            m_read_byte_reg     <= (op_reg == OP_HOST_RD) ? bytes_cur[0] : '0;
            m_tx_word_valid_reg <= (op_reg == OP_TX_EMPTY) && cnt_nz;
            m_tx_word_reg       <= ((op_reg == OP_TX_EMPTY) && cnt_nz)
                                   ? {bytes_cur[2], bytes_cur[1], bytes_cur[0], 6'd0, cnt_reg}
                                   : '0;
            m_byte_count_reg    <= ((op_reg == OP_TX_EMPTY) || (op_reg == OP_RX_WORD))
                                   ? cnt_reg : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = m_accepted_reg;
    assign m_read_byte     = m_read_byte_reg;
    assign m_tx_word_valid = m_tx_word_valid_reg;
    assign m_tx_word       = m_tx_word_reg;
    assign m_byte_count    = m_byte_count_reg;
    assign m_tx_irq_mask   = irq_en_reg;

`ifndef SYNTH
    a_cnt_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH || state_reg == ST_POP) |-> (cnt_reg <= lim_reg))
        else $error("byte count ran past request limit");

    a_pend_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_POP || state_reg == ST_DONE))
        else $error("pending RAM read outside pop/done");

    a_no_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push_go && pop_go))
        else $error("RAM write and read in one cycle");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised without completing a request");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push_go |=> (rp_reg[$past(ring_reg)] != wp_reg[$past(ring_reg)]))
        else $error("push left ring looking empty");
`endif

endmodule
